// File: src/ofbs_pkg.sv
// Shared types and constants for the oldest files budget selector.
// Depends on nothing; the top, the checker and the testbench import it.
`default_nettype none
package ofbs_pkg;
  localparam int TABLE_DEPTH = 32;
  localparam int COLD_DEPTH = 16;
  localparam int MAX_OUT = 32;

  localparam int TCW = $clog2(TABLE_DEPTH + 1);
  localparam int CCW = $clog2(COLD_DEPTH + 1);
  localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CAW = (COLD_DEPTH > 1) ? $clog2(COLD_DEPTH) : 1;

  localparam int SUM_W = 62;
  localparam int REQ_W = 49;
  localparam int CFG_W = 49;

  localparam logic [TCW-1:0] TABLE_FULL = TCW'(TABLE_DEPTH);
  localparam logic [CCW-1:0] COLD_FULL = CCW'(COLD_DEPTH);
  localparam logic [TCW-1:0] DRAIN_MAX =
    TCW'((TABLE_DEPTH < MAX_OUT) ? TABLE_DEPTH : MAX_OUT);

  typedef struct packed {
    logic [15:0] id;
    logic [47:0] bytes;
    logic [39:0] atime;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_MERGE = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_COLD     = 3'd0,
    OUT_SELECTED = 3'd1,
    OUT_PASSED   = 3'd2,
    OUT_DROPPED  = 3'd3,
    OUT_DRAINED  = 3'd4,
    OUT_DONE     = 3'd5
  } outcome_t;

  typedef enum logic [0:0] {
    REG_BYTES_REQUIRED = 1'b0,
    REG_AGE_CUTOFF     = 1'b1
  } reg_idx_t;
endpackage
`default_nettype wire

// File: src/ofbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module ofbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/oldest_files_budget_selector_top.sv
// Oldest files budget selector: sequencer around the sorted table RAM and
// the cold list RAM. Depends on ofbs_pkg and ofbs_ram. One command is in flight at a time.
// A check answers after its compare, or once it is inserted, with later entries shifted
// and entries evicted while the budget stays met. Merge inserts each cold entry that fits
// and drops the rest; drain sums the entries to emit, emits them and compacts the rest.
// The next command is taken once the answer is registered, or once a drain has compacted.
// Reset (rst_n low, synchronous) empties both lists and zeroes sums and registers.
`default_nettype none
module oldest_files_budget_selector_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [ofbs_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_command,
  input  wire logic [15:0]                in_file_id,
  input  wire logic [47:0]                in_file_bytes,
  input  wire logic [39:0]                in_access_time,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      out_outcome,
  output logic [15:0]                     out_entry_id,
  output logic [47:0]                     out_entry_bytes,
  output logic [39:0]                     out_entry_time,
  output logic [5:0]                      out_evicted_count,
  output logic [61:0]                     out_total_bytes,
  output logic [61:0]                     out_selected_bytes,
  output logic                            out_last
);
  import ofbs_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_CHK     = 17'h00002,
    S_INS_RD  = 17'h00004,
    S_INS_CMP = 17'h00008,
    S_INS_PUT = 17'h00010,
    S_EV_RD   = 17'h00020,
    S_EV_CMP  = 17'h00040,
    S_MG_RD   = 17'h00080,
    S_MG_LD   = 17'h00100,
    S_DR_RD   = 17'h00200,
    S_DR_SUB  = 17'h00400,
    S_EM_RD   = 17'h00800,
    S_EM_OUT  = 17'h01000,
    S_CP_RD   = 17'h02000,
    S_CP_WR   = 17'h04000,
    S_RESP    = 17'h08000,
    S_SPARE   = 17'h10000
  } state_t;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [47:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W - 47){1'b0}}, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] floor_sub(input logic [SUM_W-1:0] a,
                                                 input logic [47:0] b);
    logic [SUM_W-1:0] bx;
    bx = {{(SUM_W - 48){1'b0}}, b};
    return (a > bx) ? (a - bx) : '0;
  endfunction

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  entry_t           e_r, e_nxt;
  logic [TCW-1:0]   count_r, count_nxt;
  logic [CCW-1:0]   ccount_r, ccount_nxt;
  logic [CCW-1:0]   ci_r, ci_nxt;
  logic [TCW-1:0]   p_r, p_nxt;
  logic [TCW-1:0]   j_r, j_nxt;
  logic [TCW-1:0]   n_r, n_nxt;
  logic [5:0]       evict_r, evict_nxt;
  outcome_t         outcome_r, outcome_nxt;
  logic [SUM_W-1:0] sel_r, sel_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic [REQ_W-1:0] req_r;
  logic [39:0]      cutoff_r;

  logic             out_valid_r, out_valid_nxt;
  outcome_t         out_outcome_r, out_outcome_nxt;
  entry_t           out_entry_r, out_entry_nxt;
  logic [5:0]       out_evict_r, out_evict_nxt;
  logic [SUM_W-1:0] out_total_r, out_total_nxt;
  logic [SUM_W-1:0] out_sel_r, out_sel_nxt;
  logic             out_last_r, out_last_nxt;

  logic             t_we, c_we;
  logic [TAW-1:0]   t_waddr, t_raddr;
  logic [CAW-1:0]   c_waddr, c_raddr;
  entry_t           t_wdata, t_rdata, c_wdata, c_rdata;

  logic             out_free;
  logic [SUM_W-1:0] req_ext, nb_ext, sel_less_nb;

  assign out_free = !out_valid_r || out_ready;
  assign req_ext = {{(SUM_W - REQ_W){1'b0}}, req_r};
  assign nb_ext = {{(SUM_W - 48){1'b0}}, t_rdata.bytes};
  assign sel_less_nb = sel_r - nb_ext;

  ofbs_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  ofbs_ram #(.WIDTH(ENTRY_W), .DEPTH(COLD_DEPTH)) u_cold_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    e_nxt = e_r;
    count_nxt = count_r;
    ccount_nxt = ccount_r;
    ci_nxt = ci_r;
    p_nxt = p_r;
    j_nxt = j_r;
    n_nxt = n_r;
    evict_nxt = evict_r;
    outcome_nxt = outcome_r;
    sel_nxt = sel_r;
    total_nxt = total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_outcome_nxt = out_outcome_r;
    out_entry_nxt = out_entry_r;
    out_evict_nxt = out_evict_r;
    out_total_nxt = out_total_r;
    out_sel_nxt = out_sel_r;
    out_last_nxt = out_last_r;
    t_we = 1'b0;
    t_waddr = p_r[TAW-1:0];
    t_wdata = e_r;
    t_raddr = j_r[TAW-1:0];
    c_we = 1'b0;
    c_waddr = ccount_r[CAW-1:0];
    c_wdata = e_r;
    c_raddr = ci_r[CAW-1:0];
    in_ready = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        t_raddr = TAW'(count_r - 1'b1);
        if (in_valid) begin
          cmd_nxt = cmd_t'(in_command);
          e_nxt = '{id: in_file_id, bytes: in_file_bytes, atime: in_access_time};
          evict_nxt = '0;
          ci_nxt = '0;
          j_nxt = '0;
          case (cmd_t'(in_command))
            CMD_CHECK: begin
              total_nxt = sat_add(total_r, in_file_bytes);
              state_nxt = S_CHK;
            end
            CMD_MERGE: state_nxt = S_MG_RD;
            CMD_DRAIN: begin
              if (count_r == '0) begin
                outcome_nxt = OUT_DONE;
                state_nxt = S_RESP;
              end else begin
                n_nxt = (count_r < DRAIN_MAX) ? count_r : DRAIN_MAX;
                state_nxt = S_DR_RD;
              end
            end
            default: begin
              count_nxt = '0;
              ccount_nxt = '0;
              sel_nxt = '0;
              total_nxt = '0;
              outcome_nxt = OUT_DONE;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_CHK: begin
        state_nxt = S_RESP;
        if (cutoff_r != '0 && e_r.atime < cutoff_r) begin
          if (ccount_r < COLD_FULL) begin
            c_we = 1'b1;
            ccount_nxt = ccount_r + 1'b1;
            sel_nxt = sat_add(sel_r, e_r.bytes);
            outcome_nxt = OUT_COLD;
          end else begin
            outcome_nxt = OUT_DROPPED;
          end
        end else if (sel_r < req_ext ||
                     (count_r != '0 && e_r.atime < t_rdata.atime)) begin
          if (count_r >= TABLE_FULL) begin
            outcome_nxt = OUT_DROPPED;
          end else begin
            p_nxt = count_r;
            state_nxt = S_INS_RD;
          end
        end else begin
          outcome_nxt = OUT_PASSED;
        end
      end
      S_INS_RD: begin
        t_raddr = TAW'(p_r - 1'b1);
        state_nxt = (p_r == '0) ? S_INS_PUT : S_INS_CMP;
      end
      S_INS_CMP: begin
        if (t_rdata.atime > e_r.atime) begin
          t_we = 1'b1;
          t_wdata = t_rdata;
          p_nxt = p_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        t_we = 1'b1;
        count_nxt = count_r + 1'b1;
        if (cmd_r == CMD_CHECK) begin
          sel_nxt = sat_add(sel_r, e_r.bytes);
          outcome_nxt = OUT_SELECTED;
          state_nxt = S_EV_RD;
        end else begin
          ci_nxt = ci_r + 1'b1;
          state_nxt = S_MG_RD;
        end
      end
      S_EV_RD: begin
        t_raddr = TAW'(count_r - 1'b1);
        state_nxt = (count_r == '0) ? S_RESP : S_EV_CMP;
      end
      S_EV_CMP: begin
        if (sel_r < nb_ext || sel_less_nb < req_ext) begin
          state_nxt = S_RESP;
        end else begin
          sel_nxt = sel_less_nb;
          count_nxt = count_r - 1'b1;
          evict_nxt = evict_r + 1'b1;
          state_nxt = S_EV_RD;
        end
      end
      S_MG_RD: begin
        if (ci_r == ccount_r) begin
          ccount_nxt = '0;
          outcome_nxt = (evict_r != '0) ? OUT_DROPPED : OUT_DONE;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_MG_LD;
        end
      end
      S_MG_LD: begin
        e_nxt = c_rdata;
        if (count_r >= TABLE_FULL) begin
          sel_nxt = floor_sub(sel_r, c_rdata.bytes);
          evict_nxt = evict_r + 1'b1;
          ci_nxt = ci_r + 1'b1;
          state_nxt = S_MG_RD;
        end else begin
          p_nxt = count_r;
          state_nxt = S_INS_RD;
        end
      end
      S_DR_RD: begin
        if (j_r == n_r) begin
          j_nxt = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_DR_SUB;
        end
      end
      S_DR_SUB: begin
        sel_nxt = floor_sub(sel_r, t_rdata.bytes);
        j_nxt = j_r + 1'b1;
        state_nxt = S_DR_RD;
      end
      S_EM_RD: state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_outcome_nxt = OUT_DRAINED;
          out_entry_nxt = t_rdata;
          out_evict_nxt = '0;
          out_total_nxt = total_r;
          out_sel_nxt = sel_r;
          out_last_nxt = (j_r + 1'b1 == n_r);
          j_nxt = j_r + 1'b1;
          if (j_r + 1'b1 == n_r) begin
            p_nxt = n_r;
            state_nxt = S_CP_RD;
          end else begin
            state_nxt = S_EM_RD;
          end
        end
      end
      S_CP_RD: begin
        t_raddr = p_r[TAW-1:0];
        if (p_r == count_r) begin
          count_nxt = count_r - n_r;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CP_WR;
        end
      end
      S_CP_WR: begin
        t_we = 1'b1;
        t_waddr = TAW'(p_r - n_r);
        t_wdata = t_rdata;
        p_nxt = p_r + 1'b1;
        state_nxt = S_CP_RD;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_outcome_nxt = outcome_r;
          out_entry_nxt = (cmd_r == CMD_CHECK) ? e_r : '0;
          out_evict_nxt = evict_r;
          out_total_nxt = total_r;
          out_sel_nxt = sel_r;
          out_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ccount_r <= '0;
      sel_r <= '0;
      total_r <= '0;
      req_r <= '0;
      cutoff_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ccount_r <= ccount_nxt;
      sel_r <= sel_nxt;
      total_r <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BYTES_REQUIRED: req_r <= cfg_wdata[REQ_W-1:0];
          REG_AGE_CUTOFF:     cutoff_r <= cfg_wdata[39:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    e_r <= e_nxt;
    ci_r <= ci_nxt;
    p_r <= p_nxt;
    j_r <= j_nxt;
    n_r <= n_nxt;
    evict_r <= evict_nxt;
    outcome_r <= outcome_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_entry_r <= out_entry_nxt;
    out_evict_r <= out_evict_nxt;
    out_total_r <= out_total_nxt;
    out_sel_r <= out_sel_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_entry_id = out_entry_r.id;
  assign out_entry_bytes = out_entry_r.bytes;
  assign out_entry_time = out_entry_r.atime;
  assign out_evicted_count = out_evict_r;
  assign out_total_bytes = out_total_r;
  assign out_selected_bytes = out_sel_r;
  assign out_last = out_last_r;

`ifndef SYNTHESIS
  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= TABLE_FULL)
    else $error("table count exceeds depth");
  a_cold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ccount_r <= COLD_FULL)
    else $error("cold count exceeds depth");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted command produced no work");
  a_mid_beat_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_outcome == OUT_DRAINED)
    else $error("non-final beat outside drain");
  a_table_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    t_we |-> {1'b0, t_waddr} < {1'b0, TAW'(TABLE_DEPTH - 1)} + 1'b1)
    else $error("table write outside depth");
`endif
endmodule
`default_nettype wire

// File: test/ofbs_checker.sv
`timescale 1ns / 100ps
// Watches the command and result channels of the budget selector, models the table,
// cold list, and sums, and compares every result beat. Depends on ofbs_pkg.
module ofbs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [48:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_file_id,
  input  logic [47:0] in_file_bytes,
  input  logic [39:0] in_access_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_outcome,
  input  logic [15:0] out_entry_id,
  input  logic [47:0] out_entry_bytes,
  input  logic [39:0] out_entry_time,
  input  logic [5:0]  out_evicted_count,
  input  logic [61:0] out_total_bytes,
  input  logic [61:0] out_selected_bytes,
  input  logic        out_last,
  output int          error_count,
  output int          pending_count,
  output int          beat_count
);
  import ofbs_pkg::*;

  localparam logic [61:0] SUM_TOP = {62{1'b1}};

  typedef struct packed {
    logic [2:0]  outcome;
    logic [15:0] id;
    logic [47:0] bytes;
    logic [39:0] atime;
    logic [5:0]  evicted;
    logic [61:0] total;
    logic [61:0] selected;
    logic        last;
  } beat_t;

  entry_t      sel_table[TABLE_DEPTH];
  int          sel_count;
  entry_t      cold[COLD_DEPTH];
  int          cold_count;
  logic [61:0] sel_sum, tot_sum;
  logic [48:0] budget;
  logic [39:0] cutoff;
  beat_t       expected_beats[$];

  function automatic logic [61:0] sum_add(logic [61:0] a, logic [61:0] b);
    logic [62:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[62] ? SUM_TOP : s[61:0];
  endfunction

  function automatic logic [61:0] sum_sub(logic [61:0] a, logic [61:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic bit table_put(entry_t e);
    int p;
    if (sel_count >= TABLE_DEPTH) return 0;
    p = sel_count;
    while (p > 0 && sel_table[p-1].atime > e.atime) begin
      sel_table[p] = sel_table[p-1];
      p--;
    end
    sel_table[p] = e;
    sel_count++;
    return 1;
  endfunction

  function automatic void push_beat(outcome_t oc, entry_t e, int ev, bit lst);
    beat_t b;
    b.outcome = oc;
    b.id = e.id;
    b.bytes = e.bytes;
    b.atime = e.atime;
    b.evicted = ev[5:0];
    b.total = tot_sum;
    b.selected = sel_sum;
    b.last = lst;
    expected_beats = {expected_beats, b};
  endfunction

  function automatic void predict_command(cmd_t c, entry_t e);
    outcome_t oc;
    entry_t z;
    int ev, n;
    z = '0;
    ev = 0;
    case (c)
      CMD_CHECK: begin
        tot_sum = sum_add(tot_sum, 62'(e.bytes));
        if (cutoff != 0 && e.atime < cutoff) begin
          if (cold_count < COLD_DEPTH) begin
            cold[cold_count] = e;
            cold_count++;
            sel_sum = sum_add(sel_sum, 62'(e.bytes));
            oc = OUT_COLD;
          end else begin
            oc = OUT_DROPPED;
          end
        end else if (sel_sum < 62'(budget) ||
                     (sel_count > 0 && e.atime < sel_table[sel_count-1].atime)) begin
          if (table_put(e)) begin
            sel_sum = sum_add(sel_sum, 62'(e.bytes));
            while (sel_count > 0) begin
              if (sel_sum < 62'(sel_table[sel_count-1].bytes) ||
                  sel_sum - 62'(sel_table[sel_count-1].bytes) < 62'(budget)) break;
              sel_sum -= 62'(sel_table[sel_count-1].bytes);
              sel_count--;
              ev++;
            end
            oc = OUT_SELECTED;
          end else begin
            oc = OUT_DROPPED;
          end
        end else begin
          oc = OUT_PASSED;
        end
        push_beat(oc, e, ev, 1'b1);
      end
      CMD_MERGE: begin
        for (int i = 0; i < cold_count; i++) begin
          if (!table_put(cold[i])) begin
            sel_sum = sum_sub(sel_sum, 62'(cold[i].bytes));
            ev++;
          end
        end
        cold_count = 0;
        push_beat(ev != 0 ? OUT_DROPPED : OUT_DONE, z, ev, 1'b1);
      end
      CMD_DRAIN: begin
        if (sel_count == 0) begin
          push_beat(OUT_DONE, z, 0, 1'b1);
        end else begin
          n = (sel_count < MAX_OUT) ? sel_count : MAX_OUT;
          for (int i = 0; i < n; i++) sel_sum = sum_sub(sel_sum, 62'(sel_table[i].bytes));
          for (int i = 0; i < n; i++) push_beat(OUT_DRAINED, sel_table[i], 0, i + 1 == n);
          for (int i = n; i < sel_count; i++) sel_table[i-n] = sel_table[i];
          sel_count -= n;
        end
      end
      default: begin
        sel_count = 0;
        cold_count = 0;
        sel_sum = '0;
        tot_sum = '0;
        push_beat(OUT_DONE, z, 0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: result beat %0d: %s is %0h, expected %0h", $time, beat_count, what,
             got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    beat_t w;
    entry_t e;
    if (!rst_n) begin
      sel_count = 0;
      cold_count = 0;
      sel_sum = '0;
      tot_sum = '0;
      budget = '0;
      cutoff = '0;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BYTES_REQUIRED) budget = cfg_wdata;
        else cutoff = cfg_wdata[39:0];
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat %0d arrived with nothing expected", $time, beat_count);
          error_count++;
        end else begin
          w = expected_beats.pop_front();
          if (out_outcome !== w.outcome) report_mismatch("outcome", out_outcome, w.outcome);
          if (out_entry_id !== w.id) report_mismatch("entry_id", out_entry_id, w.id);
          if (out_entry_bytes !== w.bytes)
            report_mismatch("entry_bytes", out_entry_bytes, w.bytes);
          if (out_entry_time !== w.atime)
            report_mismatch("entry_time", out_entry_time, w.atime);
          if (out_evicted_count !== w.evicted)
            report_mismatch("evicted_count", out_evicted_count, w.evicted);
          if (out_total_bytes !== w.total)
            report_mismatch("total_bytes", out_total_bytes, w.total);
          if (out_selected_bytes !== w.selected)
            report_mismatch("selected_bytes", out_selected_bytes, w.selected);
          if (out_last !== w.last) report_mismatch("last", out_last, w.last);
        end
        beat_count++;
      end
      if (in_valid && in_ready) begin
        e.id = in_file_id;
        e.bytes = in_file_bytes;
        e.atime = in_access_time;
        predict_command(cmd_t'(in_command), e);
      end
    end
    pending_count = expected_beats.size();
  end
endmodule

// File: test/tb_oldest_files_budget_selector_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the oldest files budget selector. Depends on ofbs_pkg,
// the selector RTL and ofbs_checker, which does all prediction and comparison.
module tb_oldest_files_budget_selector_top;
  import ofbs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [48:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = '0;
  logic [15:0] in_file_id = '0;
  logic [47:0] in_file_bytes = '0;
  logic [39:0] in_access_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_outcome;
  logic [15:0] out_entry_id;
  logic [47:0] out_entry_bytes;
  logic [39:0] out_entry_time;
  logic [5:0]  out_evicted_count;
  logic [61:0] out_total_bytes;
  logic [61:0] out_selected_bytes;
  logic        out_last;
  int          error_count, pending_count, beat_count;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          hold_off_cycles = 0;
  int          hold_off_requests = 0;
  int          hold_off_taken = 0;
  int          command_count = 0;

  always #6 clk = ~clk;

  oldest_files_budget_selector_top u_dut (.*);

  ofbs_checker u_checker (.*);

  always @(negedge clk) begin
    if (hold_off_taken != hold_off_requests) begin
      hold_off_taken <= hold_off_requests;
      hold_off_cycles <= 400;
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic send_command(cmd_t c, logic [15:0] id, logic [47:0] nbytes,
                              logic [39:0] atime);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_file_id <= id;
    in_file_bytes <= nbytes;
    in_access_time <= atime;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    command_count++;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [48:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly small sizes near a shared time base, so that budgets are met and evictions happen.
  task automatic random_check(logic [39:0] base);
    logic [47:0] nb;
    logic [39:0] at;
    case ($urandom_range(9))
      0: nb = 48'({$urandom, $urandom});
      1: nb = '1;
      default: nb = 48'($urandom_range(1000));
    endcase
    case ($urandom_range(9))
      0: at = 40'({$urandom, $urandom});
      1: at = '1;
      default: at = base + 40'($urandom_range(60));
    endcase
    send_command(CMD_CHECK, 16'($urandom), nb, at);
  endtask

  task automatic random_phase(int items, int idle, int stall);
    int r;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 80) random_check(40'd1000);
      else if (r < 88)
        send_command(CMD_MERGE, 16'($urandom), 48'({$urandom, $urandom}), 40'($urandom));
      else if (r < 97)
        send_command(CMD_DRAIN, 16'($urandom), 48'({$urandom, $urandom}), 40'($urandom));
      else
        send_command(CMD_CLEAR, 16'($urandom), 48'({$urandom, $urandom}), 40'($urandom));
    end
    wait_quiet();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty drain and merge, extremes, table and cold list overflow.
    send_command(CMD_DRAIN, '0, '0, '0);
    send_command(CMD_MERGE, '1, '1, '1);
    send_command(CMD_CHECK, '0, '0, '0);
    send_command(CMD_CHECK, '1, '1, '1);
    send_command(CMD_CHECK, 16'h5a5a, '1, '1);
    send_command(CMD_CHECK, 16'h1234, 48'd7, 40'd5);
    send_command(CMD_DRAIN, '0, '0, '0);
    send_command(CMD_CLEAR, '1, '1, '1);
    wait_quiet();
    write_reg(REG_BYTES_REQUIRED, '1);
    write_reg(REG_AGE_CUTOFF, 49'(40'hff_ffff_ffff));
    for (int i = 0; i < 18; i++) send_command(CMD_CHECK, 16'(i), '1, 40'(10 + i % 3));
    send_command(CMD_CHECK, 16'h7777, 48'd1, '1);
    wait_quiet();
    write_reg(REG_AGE_CUTOFF, '0);
    for (int i = 0; i < 34; i++) send_command(CMD_CHECK, 16'(i), 48'd5, 40'(100 - i % 7));
    send_command(CMD_MERGE, '0, '0, '0);
    send_command(CMD_DRAIN, '0, '0, '0);
    send_command(CMD_DRAIN, '0, '0, '0);
    send_command(CMD_CLEAR, '0, '0, '0);
    wait_quiet();

    write_reg(REG_BYTES_REQUIRED, 49'd3000);
    write_reg(REG_AGE_CUTOFF, 49'd1020);
    random_phase(60, 0, 0);
    write_reg(REG_BYTES_REQUIRED, 49'd500);
    random_phase(60, 64, 0);
    write_reg(REG_AGE_CUTOFF, '0);
    write_reg(REG_BYTES_REQUIRED, 49'd8000);
    random_phase(60, 0, 64);
    write_reg(REG_BYTES_REQUIRED, '0);
    write_reg(REG_AGE_CUTOFF, 49'd1);
    random_phase(24, 9, 9);

    // Long receiver hold-off while commands keep coming.
    write_reg(REG_BYTES_REQUIRED, 49'd20000);
    write_reg(REG_AGE_CUTOFF, 49'd1030);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_requests++;
    for (int i = 0; i < 30; i++) random_check(40'd1000);
    send_command(CMD_DRAIN, '0, '0, '0);
    wait_quiet();
    write_reg(REG_BYTES_REQUIRED, 49'h1_ffff_ffff_ffff);
    write_reg(REG_AGE_CUTOFF, 49'(40'hff_ffff_ffff));
    random_phase(20, 9, 9);

    $display("Covered %0d commands and %0d result beats over eight register settings,",
             command_count, beat_count);
    $display("including full table, full cold list, eviction and back pressure.");
    if (error_count == 0) begin
      $display("tb_oldest_files_budget_selector_top: done, clean");
    end else begin
      $display("tb_oldest_files_budget_selector_top: done, errors");
    end
    $finish;
  end

  initial begin
    #(12 * 900000);
    $display("tb_oldest_files_budget_selector_top: done, errors");
    $finish;
  end
endmodule
